### rtl/core/conv3_pkg.sv
package conv3_pkg;

  localparam int PIXEL_W    = 16;
  localparam int COEF_W     = 16;
  localparam int VALUE_W    = 22;
  localparam int SIZE_REG_W = 11;
  localparam int COEF_REG_W = 3 * COEF_W;
  localparam int CFG_INDEX_W = 3;
  localparam int ROW_W      = 11;
  localparam int HEIGHT_MAX = 1024;
  localparam int FRAC_DROP  = 14;

  // 17-bit signed pixel times 16-bit signed coefficient
  localparam int PROD_W = PIXEL_W + COEF_W + 1;
  // nine products
  localparam int SUM_W  = PROD_W + 4;
  localparam int RND_W  = SUM_W + 1;
  localparam int SHR_W  = RND_W - FRAC_DROP;

  localparam logic signed [SHR_W-1:0] VALUE_MAX = SHR_W'(2097151);
  localparam logic signed [SHR_W-1:0] VALUE_MIN = -SHR_W'(2097152);
  localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(8192);

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_MID     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

  localparam logic [SIZE_REG_W-1:0] RESET_SIZE = 11'd1024;
  localparam logic [COEF_REG_W-1:0] RESET_COEF_EDGE = 48'h0400_0800_0400;
  localparam logic [COEF_REG_W-1:0] RESET_COEF_MID  = 48'h0800_1000_0800;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // both stored rows of one column
  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_word_t;

  // kernel edges that fall outside the frame
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_mask_t;

endpackage

### rtl/core/conv3x3_zero_padded_filter.sv
// The request that completes a result passes the window, tap, product, sum and output
// registers; it comes one row plus one pixel of requests after the result's centre pixel.
// Throughput: one request per cycle while the divider is idle; a result held at the output
// stalls the stages behind it and then input. A write to image_width or image_height holds
// off input while a bit-serial divider re-derives the output row and column.
// Reset (rst, synchronous): counters, window and registers to defaults; line memory is not
// cleared, its stale rows only reach taps hidden by the edge masks.
module conv3x3_zero_padded_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [conv3_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [conv3_pkg::COEF_REG_W-1:0]    cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,   // [15:0] pixel
  input  logic                                s_axis_tuser,   // [0] op (1 = flush)
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,   // [21:0] value, [23:22] zero
  output logic                                m_axis_tlast
);
  import conv3_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int OCW   = WW + ROW_W;
  localparam int CNT_W = $clog2(OCW + 1);
  localparam int RESET_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [OCW-1:0] RESET_TOTAL = OCW'(RESET_W * HEIGHT_MAX);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_LOAD = 3'b010,
    ST_DIV  = 3'b100
  } div_state_t;

  // configuration registers
  logic [SIZE_REG_W-1:0] width_reg, height_reg;
  logic [COEF_REG_W-1:0] coef_row [3];

  // frame position
  logic [CW-1:0]    in_column;
  logic [ROW_W-1:0] in_row;
  logic [OCW-1:0]   out_count;
  logic [ROW_W-1:0] out_row;
  logic [WW-1:0]    out_col;
  logic [OCW-1:0]   total;

  // divider
  div_state_t       state;
  logic [OCW-1:0]   div_q;
  logic [WW-1:0]    div_rem;
  logic [CNT_W-1:0] div_cnt;
  logic [WW:0]      div_sh;
  logic             div_bit;
  logic [OCW-1:0]   div_q_next;
  logic [WW-1:0]    div_rem_next;

  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  // accept-side decode
  logic             acc_go;
  logic             restart;
  logic [CW-1:0]    col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [OCW-1:0]   oc_cur;
  logic [ROW_W-1:0] orow_cur;
  logic [WW-1:0]    ocol_cur;
  logic             emit;
  logic             col_wrap;
  logic             ocol_wrap;
  logic [OCW-1:0]   oc_inc;
  logic             frame_last;
  edge_mask_t       mask_cur;
  pixel_t           px_in;

  // line memory and window stage
  line_word_t       line_mem [MAX_WIDTH];
  line_word_t       rd_word, fwd_word, cur_word, wr_word;
  logic             s1_v, s1_emit, s1_last, s1_fwd, s1_go, s1_ready;
  logic [CW-1:0]    s1_col;
  pixel_t           s1_px;
  edge_mask_t       s1_mask;
  pixel_t           win [9];
  pixel_t           win_next [9];
  pixel_t           fresh [3];

  // arithmetic stages
  logic             s2_v, s2_last, s2_ready;
  pixel_t           s2_tap [9];
  logic             s3_v, s3_last, s3_ready;
  logic signed [PROD_W-1:0] s3_prod [9];
  logic             s4_v, s4_last, s4_ready;
  logic signed [SUM_W-1:0]  s4_sum;
  logic signed [SUM_W-1:0]  sum_comb;
  logic signed [RND_W-1:0]  rounded;
  logic signed [SHR_W-1:0]  scaled;
  logic signed [VALUE_W-1:0] value_sat;
  logic             out_free;

  // effective sizes
  always_comb begin
    if (width_reg == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_reg) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_reg);
    end
    if (height_reg == '0) begin
      h_eff = ROW_W'(1);
    end else if (int'(height_reg) > HEIGHT_MAX) begin
      h_eff = ROW_W'(HEIGHT_MAX);
    end else begin
      h_eff = ROW_W'(height_reg);
    end
  end

  // one restoring-division step
  always_comb begin
    div_sh  = {div_rem, div_q[OCW-1]};
    div_bit = (div_sh >= {1'b0, w_eff});
    div_rem_next = div_bit ? WW'(div_sh - {1'b0, w_eff}) : WW'(div_sh);
    div_q_next   = {div_q[OCW-2:0], div_bit};
  end

  // position decode for the request at the input
  always_comb begin
    restart = (WW'(in_column) >= w_eff)
           || ({1'b0, in_row} > ({1'b0, h_eff} + (ROW_W+1)'(1)))
           || (out_count >= total);
    col_cur  = restart ? '0 : in_column;
    row_cur  = restart ? '0 : in_row;
    oc_cur   = restart ? '0 : out_count;
    orow_cur = restart ? '0 : out_row;
    ocol_cur = restart ? '0 : out_col;
    emit = !((row_cur == '0) || ((row_cur == ROW_W'(1)) && (col_cur == '0)));
    col_wrap   = (WW'(col_cur) + WW'(1)) >= w_eff;
    ocol_wrap  = (ocol_cur + WW'(1)) >= w_eff;
    oc_inc     = oc_cur + OCW'(1);
    frame_last = oc_inc >= total;
    mask_cur.top    = (orow_cur == '0);
    mask_cur.bottom = ({1'b0, orow_cur} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
    mask_cur.left   = (ocol_cur == '0);
    mask_cur.right  = ocol_wrap;
    px_in = s_axis_tuser ? '0 : s_axis_tdata[PIXEL_W-1:0];
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s4_ready = !s4_v || out_free;
  assign s3_ready = !s3_v || s4_ready;
  assign s2_ready = !s2_v || s3_ready;
  assign s1_go    = s1_v && (!s1_emit || s2_ready);
  assign s1_ready = !s1_v || s1_go;
  assign s_axis_tready = s1_ready && (state == ST_RUN);
  assign acc_go = s_axis_tvalid && s_axis_tready;

  // configuration, counters, divider
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg   <= RESET_SIZE;
      height_reg  <= RESET_SIZE;
      coef_row[0] <= RESET_COEF_EDGE;
      coef_row[1] <= RESET_COEF_MID;
      coef_row[2] <= RESET_COEF_EDGE;
      in_column   <= '0;
      in_row      <= '0;
      out_count   <= '0;
      out_row     <= '0;
      out_col     <= '0;
      total       <= RESET_TOTAL;
      state       <= ST_RUN;
      div_q       <= '0;
      div_rem     <= '0;
      div_cnt     <= '0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (acc_go) begin
            in_column <= col_wrap ? '0 : CW'(col_cur + CW'(1));
            in_row    <= col_wrap ? ROW_W'(row_cur + ROW_W'(1)) : row_cur;
            if (emit) begin
              if (frame_last) begin
                in_column <= '0;
                in_row    <= '0;
                out_count <= '0;
                out_row   <= '0;
                out_col   <= '0;
              end else begin
                out_count <= oc_inc;
                out_col   <= ocol_wrap ? '0 : WW'(ocol_cur + WW'(1));
                out_row   <= ocol_wrap ? ROW_W'(orow_cur + ROW_W'(1)) : orow_cur;
              end
            end else begin
              out_count <= oc_cur;
              out_row   <= orow_cur;
              out_col   <= ocol_cur;
            end
          end
        end
        ST_LOAD: begin
          total   <= OCW'(w_eff) * OCW'(h_eff);
          div_q   <= out_count;
          div_rem <= '0;
          div_cnt <= CNT_W'(OCW);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == CNT_W'(1)) begin
            out_row <= div_q_next[ROW_W-1:0];
            out_col <= div_rem_next;
            state   <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg <= cfg_data[SIZE_REG_W-1:0];
            state     <= ST_LOAD;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg <= cfg_data[SIZE_REG_W-1:0];
            state      <= ST_LOAD;
          end
          REG_COEF_TOP:    coef_row[0] <= cfg_data;
          REG_COEF_MID:    coef_row[1] <= cfg_data;
          REG_COEF_BOTTOM: coef_row[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // line memory: read on accept, write back as the request leaves the window stage
  always_ff @(posedge clk) begin
    if (acc_go) begin
      rd_word  <= line_mem[col_cur];
      fwd_word <= wr_word;
      s1_fwd   <= s1_go && (s1_col == col_cur);
      s1_col   <= col_cur;
      s1_px    <= px_in;
      s1_emit  <= emit;
      s1_last  <= emit && frame_last;
      s1_mask  <= mask_cur;
    end
    if (s1_go) begin
      line_mem[s1_col] <= wr_word;
    end
  end

  // window stage
  always_comb begin
    // same column written in the cycle this one was read: take the write data
    cur_word = s1_fwd ? fwd_word : rd_word;
    wr_word.upper = cur_word.lower;
    wr_word.lower = s1_px;
    fresh[0] = cur_word.upper;
    fresh[1] = cur_word.lower;
    fresh[2] = s1_px;
    for (int r = 0; r < 3; r++) begin
      win_next[3*r]     = win[3*r + 1];
      win_next[3*r + 1] = win[3*r + 2];
      win_next[3*r + 2] = fresh[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (s1_ready) begin
        s1_v <= acc_go;
      end
      if (s1_go) begin
        win <= win_next;
      end
    end
  end

  // masked taps
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_ready) begin
      s2_v <= s1_v && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_last <= s1_last;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r == 0 && s1_mask.top) || (r == 2 && s1_mask.bottom)
              || (c == 0 && s1_mask.left) || (c == 2 && s1_mask.right)) begin
            s2_tap[3*r + c] <= '0;
          end else begin
            s2_tap[3*r + c] <= win_next[3*r + c];
          end
        end
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_ready) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_last <= s2_last;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s3_prod[3*r + c] <= $signed({1'b0, s2_tap[3*r + c]})
                            * $signed(coef_row[r][COEF_W*c +: COEF_W]);
        end
      end
    end
  end

  // sum
  always_comb begin
    sum_comb = '0;
    for (int i = 0; i < 9; i++) begin
      sum_comb = sum_comb + SUM_W'(s3_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (s4_ready) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_last <= s3_last;
      s4_sum  <= sum_comb;
    end
  end

  // round half up, dropping the 14 fraction bits, and saturate
  always_comb begin
    rounded = RND_W'(s4_sum) + $signed(ROUND_HALF);
    scaled  = rounded[RND_W-1:FRAC_DROP];
    priority if (scaled > VALUE_MAX) begin
      value_sat = VALUE_MAX[VALUE_W-1:0];
    end else if (scaled < VALUE_MIN) begin
      value_sat = VALUE_MIN[VALUE_W-1:0];
    end else begin
      value_sat = scaled[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_axis_tdata <= {2'b00, value_sat};
      m_axis_tlast <= s4_last;
    end
  end

endmodule
